>>> design/cabf_pkg.sv
package cabf_pkg;

	localparam int DATA_W      = 16;
	localparam int MODE_W      = 5;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 72;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// raw operation codes as they arrive on the stream
	localparam logic [MODE_W-1:0] MODE_ADC = 5'd0;
	localparam logic [MODE_W-1:0] MODE_AND = 5'd1;
	localparam logic [MODE_W-1:0] MODE_BIT = 5'd2;
	localparam logic [MODE_W-1:0] MODE_CMP = 5'd3;
	localparam logic [MODE_W-1:0] MODE_CPX = 5'd4;
	localparam logic [MODE_W-1:0] MODE_CPY = 5'd5;
	localparam logic [MODE_W-1:0] MODE_EOR = 5'd6;
	localparam logic [MODE_W-1:0] MODE_LDA = 5'd7;
	localparam logic [MODE_W-1:0] MODE_LDX = 5'd8;
	localparam logic [MODE_W-1:0] MODE_LDY = 5'd9;
	localparam logic [MODE_W-1:0] MODE_ORA = 5'd10;
	localparam logic [MODE_W-1:0] MODE_SBC = 5'd11;
	localparam logic [MODE_W-1:0] MODE_INC = 5'd12;
	localparam logic [MODE_W-1:0] MODE_DEC = 5'd13;
	localparam logic [MODE_W-1:0] MODE_ASL = 5'd14;
	localparam logic [MODE_W-1:0] MODE_LSR = 5'd15;
	localparam logic [MODE_W-1:0] MODE_ROL = 5'd16;
	localparam logic [MODE_W-1:0] MODE_ROR = 5'd17;
	localparam logic [MODE_W-1:0] MODE_TRB = 5'd18;
	localparam logic [MODE_W-1:0] MODE_TSB = 5'd19;

	typedef enum logic [4:0] {
		OP_ADC, OP_AND, OP_BIT, OP_CMP, OP_CPX, OP_CPY, OP_EOR, OP_LDA,
		OP_LDX, OP_LDY, OP_ORA, OP_SBC, OP_INC, OP_DEC, OP_ASL, OP_LSR,
		OP_ROL, OP_ROR, OP_TRB, OP_TSB, OP_NOP
	} op_t;

	// decoded item handed from the front to the back
	typedef struct packed {
		op_t               op;
		logic              rmw;
		logic              wide;
		logic              decimal;
		logic [DATA_W-1:0] operand;
	} item_t;

endpackage

>>> design/cabf_front.sv
module cabf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [cabf_pkg::IN_TDATA_W-1:0] in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cabf_pkg::item_t                 out_item
);
	import cabf_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t dec_item;
	logic  [MODE_W-1:0] mode;

	assign mode = in_data[MODE_W-1:0];

	always_comb begin
		dec_item.wide    = in_data[MODE_W];
		dec_item.decimal = in_data[MODE_W+1];
		dec_item.operand = in_data[MODE_W+2 +: DATA_W];
		dec_item.rmw     = 1'b0;
		case (mode)
			MODE_ADC: dec_item.op = OP_ADC;
			MODE_AND: dec_item.op = OP_AND;
			MODE_BIT: dec_item.op = OP_BIT;
			MODE_CMP: dec_item.op = OP_CMP;
			MODE_CPX: dec_item.op = OP_CPX;
			MODE_CPY: dec_item.op = OP_CPY;
			MODE_EOR: dec_item.op = OP_EOR;
			MODE_LDA: dec_item.op = OP_LDA;
			MODE_LDX: dec_item.op = OP_LDX;
			MODE_LDY: dec_item.op = OP_LDY;
			MODE_ORA: dec_item.op = OP_ORA;
			MODE_SBC: dec_item.op = OP_SBC;
			MODE_INC: dec_item.op = OP_INC;
			MODE_DEC: dec_item.op = OP_DEC;
			MODE_ASL: dec_item.op = OP_ASL;
			MODE_LSR: dec_item.op = OP_LSR;
			MODE_ROL: dec_item.op = OP_ROL;
			MODE_ROR: dec_item.op = OP_ROR;
			MODE_TRB: dec_item.op = OP_TRB;
			MODE_TSB: dec_item.op = OP_TSB;
			default:  dec_item.op = OP_NOP;
		endcase
		// read-modify-write group
		if (mode inside {[MODE_INC:MODE_TSB]}) begin
			dec_item.rmw = 1'b1;
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= dec_item;
		end
	end

endmodule

>>> design/cabf_queue.sv
module cabf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  cabf_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output cabf_pkg::item_t pop_item
);
	import cabf_pkg::*;

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> design/cabf_back.sv
module cabf_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  cabf_pkg::item_t                  in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cabf_pkg::OUT_TDATA_W-1:0] out_data
);
	import cabf_pkg::*;

	// register file and flags
	logic [DATA_W-1:0] acc_q, x_q, y_q;
	logic              n_q, v_q, z_q, c_q;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [DATA_W-1:0] acc_d, x_d, y_d, mod_d;
	logic              n_d, v_d, z_d, c_d;
	logic              exec;

	logic [DATA_W-1:0] msk, a, b, x, y;
	logic [DATA_W-1:0] r, m;
	logic [DATA_W:0]   sum, diff, cmp_diff;
	logic [17:0]       bcd_a;
	logic [17:0]       bcd_s;
	logic              br_in;
	logic [DATA_W-1:0] add_r, sub_r;

	// digit adders, carries after digit 1 and digit 3 on top
	function automatic logic [17:0] bcd_add(input logic [15:0] av, input logic [15:0] bv,
	                                        input logic cin);
		logic       c;
		logic [4:0] n;
		logic [15:0] rr;
		logic [1:0] cs;
		c  = cin;
		rr = '0;
		cs = '0;
		for (int i = 0; i < 4; i++) begin
			n = {1'b0, av[4*i +: 4]} + {1'b0, bv[4*i +: 4]} + {4'b0, c};
			if (n > 5'd9) begin
				n = n - 5'd10;
				c = 1'b1;
			end else begin
				c = 1'b0;
			end
			rr[4*i +: 4] = n[3:0];
			if (i == 1) cs[0] = c;
			if (i == 3) cs[1] = c;
		end
		return {cs, rr};
	endfunction

	// digit subtract: a corrected digit is ored in at full byte width
	function automatic logic [17:0] bcd_sub(input logic [15:0] av, input logic [15:0] bv,
	                                        input logic bin);
		logic       brw;
		logic [7:0] n;
		logic [19:0] rr;
		logic [1:0] bs;
		brw = bin;
		rr  = '0;
		bs  = '0;
		for (int i = 0; i < 4; i++) begin
			n = {4'b0, av[4*i +: 4]} - {4'b0, bv[4*i +: 4]} - {7'b0, brw};
			if (n > 8'd9) begin
				n   = n + 8'd10;
				brw = 1'b1;
			end else begin
				brw = 1'b0;
			end
			rr = rr | ({12'b0, n} << (4*i));
			if (i == 1) bs[0] = brw;
			if (i == 3) bs[1] = brw;
		end
		return {bs, rr[15:0]};
	endfunction

	function automatic logic top_bit(input logic [15:0] val, input logic wd);
		return wd ? val[15] : val[7];
	endfunction

	assign exec     = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	always_comb begin
		msk   = in_item.wide ? 16'hffff : 16'h00ff;
		b     = in_item.operand & msk;
		a     = acc_q & msk;
		x     = x_q & msk;
		y     = y_q & msk;
		br_in = !c_q;

		sum   = {1'b0, a} + {1'b0, b} + {16'b0, c_q};
		diff  = {1'b0, a} - {1'b0, b} - {16'b0, br_in};
		bcd_a = bcd_add(a, b, c_q);
		bcd_s = bcd_sub(a, b, br_in);
		add_r = in_item.decimal ? bcd_a[15:0] : sum[DATA_W-1:0];
		sub_r = (in_item.decimal ? bcd_s[15:0] : diff[DATA_W-1:0]) & msk;

		cmp_diff = '0;
		r        = '0;
		m        = b;

		acc_d = acc_q;
		x_d   = x_q;
		y_d   = y_q;
		n_d   = n_q;
		v_d   = v_q;
		z_d   = z_q;
		c_d   = c_q;

		case (in_item.op)
			OP_ADC: begin
				r = add_r;
				if (in_item.decimal) begin
					c_d = in_item.wide ? bcd_a[17] : bcd_a[16];
				end else begin
					c_d = in_item.wide ? sum[16] : sum[8];
				end
				v_d = top_bit(~(a ^ b) & (a ^ r), in_item.wide);
			end
			OP_SBC: begin
				r = sub_r;
				if (in_item.decimal) begin
					c_d = !(in_item.wide ? bcd_s[17] : bcd_s[16]);
				end else begin
					c_d = !diff[DATA_W];
				end
				v_d = top_bit((a ^ b) & (a ^ r), in_item.wide);
			end
			OP_AND: r = a & b;
			OP_EOR: r = a ^ b;
			OP_ORA: r = a | b;
			OP_LDA, OP_LDX, OP_LDY: r = b;
			OP_CMP, OP_CPX, OP_CPY: begin
				case (in_item.op)
					OP_CPX:  cmp_diff = {1'b0, x} - {1'b0, b};
					OP_CPY:  cmp_diff = {1'b0, y} - {1'b0, b};
					default: cmp_diff = {1'b0, a} - {1'b0, b};
				endcase
				r   = cmp_diff[DATA_W-1:0];
				c_d = !cmp_diff[DATA_W];
			end
			OP_INC: m = b + 1'b1;
			OP_DEC: m = b - 1'b1;
			OP_ASL: begin
				m   = b << 1;
				c_d = top_bit(b, in_item.wide);
			end
			OP_LSR: begin
				m   = b >> 1;
				c_d = b[0];
			end
			OP_ROL: begin
				m   = (b << 1) | {15'b0, c_q};
				c_d = top_bit(b, in_item.wide);
			end
			OP_ROR: begin
				m = b >> 1;
				if (in_item.wide) begin
					m[15] = c_q;
				end else begin
					m[7] = c_q;
				end
				c_d = b[0];
			end
			OP_TRB: m = b & ~a;
			OP_TSB: m = b | a;
			default: ;
		endcase
		m = m & msk;
		r = r & msk;

		// flag n and z (only z for TRB and TSB), and v for BIT
		case (in_item.op)
			OP_ADC, OP_SBC, OP_AND, OP_EOR, OP_ORA, OP_LDA, OP_LDX, OP_LDY,
			OP_CMP, OP_CPX, OP_CPY: begin
				n_d = top_bit(r, in_item.wide);
				z_d = r == '0;
			end
			OP_INC, OP_DEC, OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				n_d = top_bit(m, in_item.wide);
				z_d = m == '0;
			end
			OP_BIT: begin
				n_d = top_bit(b, in_item.wide);
				v_d = in_item.wide ? b[14] : b[6];
				z_d = (a & b) == '0;
			end
			OP_TRB, OP_TSB: z_d = (a & b) == '0;
			default: ;
		endcase

		// register write-back, high byte kept when narrow
		case (in_item.op)
			OP_ADC, OP_SBC, OP_AND, OP_EOR, OP_ORA, OP_LDA: acc_d = (acc_q & ~msk) | r;
			OP_LDX: x_d = (x_q & ~msk) | r;
			OP_LDY: y_d = (y_q & ~msk) | r;
			default: ;
		endcase

		mod_d = in_item.rmw ? ((in_item.operand & ~msk) | m) : in_item.operand;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			x_q         <= '0;
			y_q         <= '0;
			n_q         <= 1'b0;
			v_q         <= 1'b0;
			z_q         <= 1'b0;
			c_q         <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
			if (exec) begin
				acc_q <= acc_d;
				x_q   <= x_d;
				y_q   <= y_d;
				n_q   <= n_d;
				v_q   <= v_d;
				z_q   <= z_d;
				c_q   <= c_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_data_q <= {4'b0, c_d, z_d, v_d, n_d, y_d, x_d, acc_d, mod_d};
		end
	end

endmodule

>>> design/cpu16_alu_bcd_flags.sv
// an accepted item passes the decode register, then the queue, then the result register
// throughput: one item per cycle while the result stream is not stalled; the accumulator,
// index and flag registers are read and written by the execute unit in the same cycle, so
// back-to-back items chain with no bubble
// reset: arst_n low clears a, x, y, all flags and every valid bit at once; the block
// takes items in the first cycle after reset is released
module cpu16_alu_bcd_flags (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// mode[4:0], wide[5], decimal[6], operand[22:7], zero pad[23]
	input  logic [cabf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// modified_value[15:0], accumulator[31:16], index_x[47:32], index_y[63:48],
	// flag_negative[64], flag_overflow[65], flag_zero[66], flag_carry[67], zero pad[71:68]
	output logic [cabf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import cabf_pkg::*;

	// front to queue
	logic  dec_valid;
	logic  dec_ready;
	item_t dec_item;

	// queue to back
	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	// front: registers the item and maps the raw code onto an operation class
	cabf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_item  (dec_item)
	);

	// short queue so a stall at the result side does not stop decode at once
	cabf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (dec_valid),
		.push_ready (dec_ready),
		.push_item  (dec_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// back: owns a, x, y and the flags, executes one item per cycle into the
	// result register while the result stream is not stalled
	cabf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
